// File: rtl/kscal_pkg.sv
// ----------------------------------------------------------------------------
// kscal_pkg
// Types and constants shared by the keyed slot cache allocator.
// ----------------------------------------------------------------------------
package kscal_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int CNT_BITS  = $clog2(SLOTS + 1);
  localparam int KEY_BITS  = 16;

  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]          op;
    logic [KEY_BITS-1:0] row_key;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic                 status;
    logic [CNT_BITS-1:0]  occupied_count;
    logic [CNT_BITS-1:0]  free_count;
  } out_item_t;

  // Write command from the sequencer to one slot cell.
  typedef struct packed {
    logic                set;
    logic                clr;
    logic [KEY_BITS-1:0] key;
  } cell_cmd_t;

endpackage

// File: rtl/keyed_slot_cache_allocator.sv
// ----------------------------------------------------------------------------
// keyed_slot_cache_allocator
// Map from row keys to buffer slots with a LIFO stack of freed slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one in_item (op, row_key). op get returns the
//   key's slot or allocates one (free stack first, then a new slot, else
//   status full); op remove frees a present key's slot; other codes query.
//   out_valid/out_stall carry one out_item per input item with the hit
//   flag, slot, status and the occupied and free counts after the item.
//   cfg_valid/cfg_ready write max_slots; cfg_ready is always high.
// Timing:
//   An item goes through accept, compare in the cell row, encode the
//   match and read the free stack top, then update and load the result.
//   The result is registered in the output register. No new item is
//   taken until the item before has left its update step; the cell row
//   and the free stack work through one item's compare-encode-update.
// Reset:
//   All slots are free, both counts are zero, max_slots is 64.
// Stall:
//   A result waits in the output register; the next item is still taken
//   and held in its update step until the output register is free.
// ----------------------------------------------------------------------------
module keyed_slot_cache_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kscal_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output kscal_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [kscal_pkg::CNT_BITS-1:0] cfg_data
);
  import kscal_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_ENC  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  in_item_t             req_r;
  logic [CNT_BITS-1:0]  max_slots_r;
  logic [CNT_BITS-1:0]  free_depth_r, free_depth_nxt;
  logic [CNT_BITS-1:0]  created_r, created_nxt;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [SLOTS-1:0]     match_vec;
  cell_cmd_t            cell_cmd [SLOTS];
  logic                 found;
  logic [SLOT_BITS-1:0] found_slot;

  logic [SLOT_BITS-1:0] stack_mem [SLOTS];
  logic [SLOT_BITS-1:0] stack_rd_r;
  logic [SLOT_BITS-1:0] stack_rd_idx;

  logic                 upd_go;
  logic                 do_alloc, do_free, do_push;
  logic [SLOT_BITS-1:0] res_slot;
  logic                 res_status;
  logic [CNT_BITS-1:0]  limit, occupied;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign upd_go    = (state_r == ST_UPD) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slots_r <= CNT_BITS'(64);
    end else if (cfg_valid && cfg_ready) begin
      max_slots_r <= cfg_data;
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = (in_valid && !in_stall) ? ST_CMP : ST_IDLE;
      ST_CMP:  state_nxt = ST_ENC;
      ST_ENC:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = upd_go ? ST_IDLE : ST_UPD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_item;
    end
  end

  // Cell row: one cell per slot, all compare the request key.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign cell_cmd[i].set = do_alloc && (res_slot == SLOT_BITS'(i));
    assign cell_cmd[i].clr = do_free  && (found_slot == SLOT_BITS'(i));
    assign cell_cmd[i].key = req_r.row_key;

    kscal_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .lookup_key (req_r.row_key),
      .cmd        (cell_cmd[i]),
      .match      (match_vec[i])
    );
  end

  kscal_encoder u_enc (
    .clk        (clk),
    .match_vec  (match_vec),
    .found      (found),
    .found_slot (found_slot)
  );

  // Read the stack top every cycle; depth is stable while an item is at work.
  assign stack_rd_idx = SLOT_BITS'(free_depth_r - 1'b1);

  always_ff @(posedge clk) begin
    stack_rd_r <= stack_mem[stack_rd_idx];
    if (do_push) begin
      stack_mem[free_depth_r[SLOT_BITS-1:0]] <= found_slot;
    end
  end

  assign limit    = (max_slots_r < CNT_BITS'(SLOTS)) ? max_slots_r : CNT_BITS'(SLOTS);
  assign occupied = created_r - free_depth_r;

  always_comb begin
    do_alloc       = 1'b0;
    do_free        = 1'b0;
    do_push        = 1'b0;
    res_slot       = found ? found_slot : '0;
    res_status     = STATUS_OK;
    free_depth_nxt = free_depth_r;
    created_nxt    = created_r;
    if (req_r.op == OP_GET) begin
      if (!found) begin
        if (free_depth_r != '0) begin
          free_depth_nxt = free_depth_r - 1'b1;
          res_slot       = stack_rd_r;
          do_alloc       = upd_go;
        end else if (occupied < limit && created_r < CNT_BITS'(SLOTS)) begin
          res_slot    = created_r[SLOT_BITS-1:0];
          created_nxt = created_r + 1'b1;
          do_alloc    = upd_go;
        end else begin
          res_status = STATUS_FULL;
          res_slot   = '0;
        end
      end
    end else if (req_r.op == OP_REMOVE) begin
      if (found && free_depth_r < CNT_BITS'(SLOTS)) begin
        free_depth_nxt = free_depth_r + 1'b1;
        do_free        = upd_go;
        do_push        = upd_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_depth_r <= '0;
      created_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        free_depth_r <= free_depth_nxt;
        created_r    <= created_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_item_r.hit            <= found;
      out_item_r.slot           <= res_slot;
      out_item_r.status         <= res_status;
      out_item_r.occupied_count <= created_nxt - free_depth_nxt;
      out_item_r.free_count     <= free_depth_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_free_le_created: assert property (@(posedge clk) disable iff (!rst_n)
    free_depth_r <= created_r)
    else $error("free stack deeper than created slots");

  a_created_bound: assert property (@(posedge clk) disable iff (!rst_n)
    created_r <= CNT_BITS'(SLOTS))
    else $error("created count beyond table size");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("key present in more than one slot");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_CMP))
    else $error("accepted item did not enter compare step");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> out_valid_r)
    else $error("update step did not load a result");

endmodule

// File: rtl/kscal_cell.sv
// ----------------------------------------------------------------------------
// kscal_cell
// One slot of the key table: in-use flag, stored key and registered match.
// ----------------------------------------------------------------------------
module kscal_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [kscal_pkg::KEY_BITS-1:0] lookup_key,
  input  kscal_pkg::cell_cmd_t          cmd,
  output logic                          match
);
  import kscal_pkg::*;

  logic                in_use_r, in_use_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic                match_r;

  always_comb begin
    in_use_nxt = in_use_r;
    if (cmd.set) begin
      in_use_nxt = 1'b1;
    end else if (cmd.clr) begin
      in_use_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      match_r  <= 1'b0;
    end else begin
      in_use_r <= in_use_nxt;
      match_r  <= in_use_r && (key_r == lookup_key);
    end
  end

  // Key holds no reset: it is only compared while the slot is in use.
  always_ff @(posedge clk) begin
    if (cmd.set) begin
      key_r <= cmd.key;
    end
  end

  assign match = match_r;

endmodule

// File: rtl/kscal_encoder.sv
// ----------------------------------------------------------------------------
// kscal_encoder
// Registered encoder of the one-hot match row into a slot index.
// ----------------------------------------------------------------------------
module kscal_encoder (
  input  logic                           clk,
  input  logic [kscal_pkg::SLOTS-1:0]     match_vec,
  output logic                           found,
  output logic [kscal_pkg::SLOT_BITS-1:0] found_slot
);
  import kscal_pkg::*;

  logic [SLOT_BITS-1:0] idx_comb;
  logic                 found_r;
  logic [SLOT_BITS-1:0] idx_r;

  // Keys in use are unique, so at most one bit is set: OR the indices.
  always_comb begin
    idx_comb = '0;
    for (int i = 0; i < SLOTS; i++) begin
      idx_comb = idx_comb | (match_vec[i] ? SLOT_BITS'(i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    found_r <= |match_vec;
    idx_r   <= idx_comb;
  end

  assign found      = found_r;
  assign found_slot = idx_r;

endmodule

// File: tb/sv/kscal_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kscal_checker
// Watches the item, result and register channels of the slot cache
// allocator. It keeps its own key table and free-slot stack to work out each
// result, then compares every result field by field against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module kscal_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  kscal_pkg::in_item_t            in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  kscal_pkg::out_item_t           out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [kscal_pkg::CNT_BITS-1:0] cfg_data,
  output int                             fail_count,
  output int                             results_due
);
  import kscal_pkg::*;

  logic                slot_busy [SLOTS];
  logic [KEY_BITS-1:0] slot_tag  [SLOTS];
  logic [SLOT_BITS-1:0] free_lifo [SLOTS];
  int unsigned         lifo_depth;
  int unsigned         slots_made;
  int unsigned         slot_cap;
  out_item_t           slot_results_due [$];
  int                  errors = 0;

  // Apply one item to the shadow table and return the result it should give.
  function automatic out_item_t predict_slot_result(in_item_t it);
    int          hit_idx;
    int unsigned limit;
    int unsigned occupied;
    out_item_t   r;
    hit_idx = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_idx < 0 && slot_busy[i] && slot_tag[i] == it.row_key) hit_idx = i;
    end
    r = '0;
    r.hit    = (hit_idx >= 0);
    r.slot   = (hit_idx >= 0) ? SLOT_BITS'(hit_idx) : '0;
    r.status = STATUS_OK;
    limit    = (slot_cap < SLOTS) ? slot_cap : SLOTS;
    case (it.op)
      OP_GET: begin
        if (hit_idx < 0) begin
          occupied = slots_made - lifo_depth;
          if (lifo_depth > 0) begin
            // reuse the most recently freed slot, even above the limit
            lifo_depth--;
            r.slot = free_lifo[lifo_depth];
            slot_busy[r.slot] = 1'b1;
            slot_tag[r.slot]  = it.row_key;
          end else if (occupied < limit && slots_made < SLOTS) begin
            r.slot = SLOT_BITS'(slots_made);
            slots_made++;
            slot_busy[r.slot] = 1'b1;
            slot_tag[r.slot]  = it.row_key;
          end else begin
            r.status = STATUS_FULL;
            r.slot   = '0;
          end
        end
      end
      OP_REMOVE: begin
        if (hit_idx >= 0 && lifo_depth < SLOTS) begin
          slot_busy[hit_idx]    = 1'b0;
          free_lifo[lifo_depth] = SLOT_BITS'(hit_idx);
          lifo_depth++;
        end
      end
      default: ; // query and the spare code leave the table alone
    endcase
    r.occupied_count = CNT_BITS'(slots_made - lifo_depth);
    r.free_count     = CNT_BITS'(lifo_depth);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
      lifo_depth = 0;
      slots_made = 0;
      slot_cap   = SLOTS;
      slot_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) slot_cap = 32'(cfg_data);
      // check the result before taking a new item, so a stray result shows up
      if (out_valid && !out_stall) begin
        if (slot_results_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, out_item);
          errors++;
        end else begin
          want = slot_results_due.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_item.hit));
          check_field("slot", 32'(want.slot), 32'(out_item.slot));
          check_field("status", 32'(want.status), 32'(out_item.status));
          check_field("occupied_count", 32'(want.occupied_count),
                      32'(out_item.occupied_count));
          check_field("free_count", 32'(want.free_count), 32'(out_item.free_count));
        end
      end
      if (in_valid && !in_stall) begin
        slot_results_due = {slot_results_due, predict_slot_result(in_item)};
      end
    end
    fail_count  <= errors;
    results_due <= slot_results_due.size();
  end

endmodule

// File: tb/sv/keyed_slot_cache_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_slot_cache_allocator_tb
// Drives the slot cache allocator with a directed opening (hits, misses,
// full gets, stale removes, reuse of freed slots under a lowered limit) and
// then random get/remove/query traffic over a shared key pool, across several
// max_slots settings and idle/stall mixes. Checking lives in kscal_checker.
// ----------------------------------------------------------------------------
module keyed_slot_cache_allocator_tb;
  import kscal_pkg::*;

  localparam logic [1:0]  OP_SPARE       = 2'd3;
  localparam int          POOL_KEYS      = 96;
  localparam int          PHASES         = 8;
  localparam int          PHASE_ITEMS    = 240;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_CAP [PHASES] = '{127, 64, 20, 0, 1, 64, 2, 33};

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CNT_BITS-1:0] cfg_data;

  int                  fail_count;
  int                  results_due;
  int                  send_gap_pct;
  int                  stall_pct;
  int                  quiet_cycles = 0;
  logic [KEY_BITS-1:0] key_pool [POOL_KEYS];

  keyed_slot_cache_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  kscal_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // End the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(logic [1:0] op, logic [KEY_BITS-1:0] key);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_item.op      = op;
    in_item.row_key = key;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drain all results, let the pipeline settle, then write max_slots.
  task automatic write_cap(int unsigned cap);
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = CNT_BITS'(cap);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0:       begin send_gap_pct = 0;  stall_pct = 0;  end
      1:       begin send_gap_pct = 85; stall_pct = 0;  end
      2:       begin send_gap_pct = 0;  stall_pct = 85; end
      default: begin send_gap_pct = 11; stall_pct = 11; end
    endcase
  endtask

  initial begin
    logic [1:0]          op;
    logic [KEY_BITS-1:0] key;
    int                  pick;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    set_idling(0);
    // keep keys from the directed part in the pool so their slots get freed
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'hAAAA;
    key_pool[3] = 16'h0001;
    key_pool[4] = 16'h0002;
    key_pool[5] = 16'h1234;
    for (int i = 6; i < POOL_KEYS; i++) key_pool[i] = KEY_BITS'($urandom_range(65535));
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: small limit, hits, full, stale remove, reuse from stack.
    write_cap(3);
    set_idling(3);
    send_op(OP_GET, 16'h0000);
    send_op(OP_GET, 16'hFFFF);
    send_op(OP_GET, 16'h0000);
    send_op(OP_QUERY, 16'hFFFF);
    send_op(OP_SPARE, 16'h1234);
    send_op(OP_GET, 16'h1234);
    send_op(OP_GET, 16'h5555);
    send_op(OP_REMOVE, 16'h5555);
    send_op(OP_REMOVE, 16'hFFFF);
    send_op(OP_GET, 16'hAAAA);
    send_op(OP_REMOVE, 16'h0000);
    send_op(OP_REMOVE, 16'h1234);
    send_op(OP_QUERY, 16'h0000);
    send_op(OP_SPARE, 16'hAAAA);
    // lower the limit below what was created: stacked slots still reusable
    write_cap(1);
    send_op(OP_GET, 16'h0001);
    send_op(OP_GET, 16'h0002);
    send_op(OP_GET, 16'h0003);
    write_cap(0);
    send_op(OP_GET, 16'h0004);
    send_op(OP_GET, 16'h0001);
    send_op(OP_REMOVE, 16'h0002);
    send_op(OP_GET, 16'h0004);
    send_op(OP_GET, 16'hFFFF);

    // Random phases over a shared key pool.
    for (int p = 0; p < PHASES; p++) begin
      write_cap(PHASE_CAP[p]);
      set_idling(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 50)      op = OP_GET;
        else if (pick < 80) op = OP_REMOVE;
        else if (pick < 95) op = OP_QUERY;
        else                op = OP_SPARE;
        // gets mostly hit the pool so stray keys do not clog the table
        if ((op == OP_GET && $urandom_range(99) < 95) || $urandom_range(99) < 70) begin
          key = key_pool[$urandom_range(POOL_KEYS - 1)];
        end else begin
          key = KEY_BITS'($urandom_range(65535));
        end
        send_op(op, key);
      end
    end
    in_valid = 1'b0;

    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kscal_pkg.sv
rtl/kscal_cell.sv
rtl/kscal_encoder.sv
rtl/keyed_slot_cache_allocator.sv
tb/sv/kscal_checker.sv
tb/sv/keyed_slot_cache_allocator_tb.sv
